@@ design/lcg48_pkg.sv @@
// Package for the 48-bit LCG draw unit.
// Holds the generator constants and the action codes; no dependencies.
package lcg48_pkg;

  // Generator constants: state = state * MULT + ADD mod 2^48
  localparam logic [34:0] LCG_MULT = 35'h5_DEEC_E66D;
  localparam logic [47:0] LCG_ADD  = 48'hB;

  // Action codes carried in the input tuser field
  localparam logic [2:0] ACT_SEED  = 3'd0;
  localparam logic [2:0] ACT_INT   = 3'd1;
  localparam logic [2:0] ACT_BND   = 3'd2;
  localparam logic [2:0] ACT_LONG  = 3'd3;
  localparam logic [2:0] ACT_BOOL  = 3'd4;
  localparam logic [2:0] ACT_FLT   = 3'd5;
  localparam logic [2:0] ACT_DBL   = 3'd6;
  localparam logic [2:0] ACT_NONE  = 3'd7;

endpackage

@@ design/lcg48_random_draw_unit.sv @@
// A seed loads the state directly. Int, boolean, float bits and power-of-two bounds
// advance the state once, long and double bits twice, before the result is registered;
// other bounds run the 31-step serial remainder unit and an overflow check per attempt,
// redrawing on rejection. Throughput: one item at a time; the chunked 16x35 multiplier
// works in 16-bit slices. Reset (async, active low) loads the state of seed zero.
// Top level of the 48-bit LCG draw unit; uses lcg48_pkg.
module lcg48_random_draw_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // seed_value[63:0], bound[94:64], zero[95]
  input  logic [2:0]  s_axis_tuser,   // action[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // value[63:0]
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DRAW = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]  st_q;
  logic [47:0] lcg_q;
  logic [47:0] acc_q;
  logic [4:0]  cnt_q;
  logic [2:0]  act_q;
  logic [30:0] bound_q;
  logic        second_q;
  logic [31:0] hi_q;
  logic [30:0] draw_q;
  logic [30:0] div_q;
  logic [30:0] rem_q;
  logic [63:0] res_q;
  logic        m_valid_q;
  logic [63:0] m_data_q;

  logic        in_xfer;
  logic [15:0] chunk;
  logic [50:0] chunk_prod;
  logic [47:0] chunk_term;
  logic [47:0] acc_d;
  logic [31:0] d32;
  logic [30:0] d31;
  logic [25:0] d26;
  logic [26:0] d27;
  logic        bound_pow2;
  logic [61:0] pow2_prod;
  logic [31:0] trial;
  logic [30:0] rem_d;
  logic [32:0] chk;
  logic        out_free;

  assign s_axis_tready = (st_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign out_free      = !m_valid_q || m_axis_tready;

  // Chunked state multiply: one 16-bit slice of the state per cycle
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    chunk = lcg_q[15:0];
      2'd1:    chunk = lcg_q[31:16];
      default: chunk = lcg_q[47:32];
    endcase
    chunk_prod = 51'(chunk) * 51'(lcg48_pkg::LCG_MULT);
    case (cnt_q[1:0])
      2'd0:    chunk_term = chunk_prod[47:0];
      2'd1:    chunk_term = {chunk_prod[31:0], 16'd0};
      default: chunk_term = {chunk_prod[15:0], 32'd0};
    endcase
    acc_d = ((cnt_q[1:0] == 2'd0) ? lcg48_pkg::LCG_ADD : acc_q) + chunk_term;
  end

  // Raw draws from the top of the freshly advanced state
  assign d32 = lcg_q[47:16];
  assign d31 = lcg_q[47:17];
  assign d26 = lcg_q[47:22];
  assign d27 = lcg_q[47:21];

  assign bound_pow2 = ((bound_q & (bound_q - 31'd1)) == 31'd0);
  assign pow2_prod  = 62'(bound_q) * 62'(d31);

  // Restoring remainder step, one dividend bit per cycle
  always_comb begin
    trial = {rem_q, div_q[30]};
    if (trial >= {1'b0, bound_q}) begin
      rem_d = 31'(trial - {1'b0, bound_q});
    end else begin
      rem_d = trial[30:0];
    end
  end

  // Overflow test of the bounded draw: reject when above 2^31 - 1
  assign chk = {2'b00, draw_q} - {2'b00, rem_q} + {2'b00, bound_q} - 33'd1;

  // Raise the output when a result moves in, drop it once it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (st_q == ST_FIN && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      lcg_q     <= 48'(lcg48_pkg::LCG_MULT);
      acc_q     <= '0;
      cnt_q     <= '0;
      act_q     <= lcg48_pkg::ACT_NONE;
      bound_q   <= '0;
      second_q  <= 1'b0;
      hi_q      <= '0;
      draw_q    <= '0;
      div_q     <= '0;
      rem_q     <= '0;
      res_q     <= '0;
      m_data_q  <= '0;
    end else begin
      case (st_q)
        ST_IDLE: begin
          if (in_xfer) begin
            act_q    <= s_axis_tuser;
            bound_q  <= s_axis_tdata[94:64];
            second_q <= 1'b0;
            cnt_q    <= '0;
            if (s_axis_tuser == lcg48_pkg::ACT_SEED) begin
              lcg_q <= s_axis_tdata[47:0] ^ 48'(lcg48_pkg::LCG_MULT);
            end else if (s_axis_tuser != lcg48_pkg::ACT_NONE) begin
              st_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          acc_q <= acc_d;
          if (cnt_q[1:0] == 2'd2) begin
            lcg_q <= acc_d;
            st_q  <= ST_DRAW;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_DRAW: begin
          cnt_q <= '0;
          case (act_q)
            lcg48_pkg::ACT_INT: begin
              res_q <= {{32{d32[31]}}, d32};
              st_q  <= ST_FIN;
            end
            lcg48_pkg::ACT_LONG: begin
              if (!second_q) begin
                hi_q     <= d32;
                second_q <= 1'b1;
                st_q     <= ST_MUL;
              end else begin
                res_q <= {hi_q, 32'd0} + {{32{d32[31]}}, d32};
                st_q  <= ST_FIN;
              end
            end
            lcg48_pkg::ACT_BOOL: begin
              res_q <= {63'd0, lcg_q[47]};
              st_q  <= ST_FIN;
            end
            lcg48_pkg::ACT_FLT: begin
              res_q <= {38'd0, d26};
              st_q  <= ST_FIN;
            end
            lcg48_pkg::ACT_DBL: begin
              if (!second_q) begin
                hi_q     <= {6'd0, d26};
                second_q <= 1'b1;
                st_q     <= ST_MUL;
              end else begin
                res_q <= {11'd0, hi_q[25:0], d27};
                st_q  <= ST_FIN;
              end
            end
            lcg48_pkg::ACT_BND: begin
              draw_q <= d31;
              if (bound_pow2) begin
                res_q <= {33'd0, pow2_prod[61:31]};
                st_q  <= ST_FIN;
              end else begin
                div_q <= d31;
                rem_q <= '0;
                st_q  <= ST_DIV;
              end
            end
            default: begin
              st_q <= ST_IDLE;
            end
          endcase
        end
        ST_DIV: begin
          rem_q <= rem_d;
          div_q <= {div_q[29:0], 1'b0};
          if (cnt_q == 5'd30) begin
            st_q <= ST_CHK;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_CHK: begin
          cnt_q <= '0;
          if (chk[32:31] != 2'b00) begin
            st_q <= ST_MUL;
          end else begin
            res_q <= {33'd0, rem_q};
            st_q  <= ST_FIN;
          end
        end
        ST_FIN: begin
          // hold the result until the output register is free
          if (out_free) begin
            m_data_q  <= res_q;
            st_q      <= ST_IDLE;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/lcg48_checker.sv @@
// Port-level checks for the 48-bit LCG draw unit, bound to its top level.
// Uses lcg48_pkg for the action codes.
module lcg48_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [95:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  logic in_xfer;
  logic draw_xfer;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign draw_xfer = in_xfer && (s_axis_tuser != lcg48_pkg::ACT_SEED)
                     && (s_axis_tuser != lcg48_pkg::ACT_NONE);

  // Stalled output holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // A draw keeps the input closed while it is worked on
  a_busy_after_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_xfer |=> !s_axis_tready)
    else $error("input open right after a draw transfer");

  // Seeding and the unused action leave the input open
  a_ready_after_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !draw_xfer |=> s_axis_tready)
    else $error("input closed after a seed transfer");

  // No result appears in the cycle after any input transfer
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(m_axis_tvalid))
    else $error("result raised too early");

endmodule

bind lcg48_random_draw_unit lcg48_checker u_lcg48_checker (.*);

@@ bench/lcg48_draw_checker.sv @@
// Checker for the 48-bit LCG draw unit: watches both stream channels, predicts each draw
// and compares it against the output transfers in order.
// Depends on lcg48_pkg for the generator constants and the action codes.
module lcg48_draw_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [95:0] req_data_i,    // seed_value[63:0], bound[94:64], zero[95]
  input  logic [2:0]  req_action_i,  // action[2:0]
  input  logic        draw_valid_i,
  input  logic        draw_ready_i,
  input  logic [63:0] draw_data_i,   // value[63:0]
  output int          mismatches_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted generator state and the draws still owed by the block
  logic [47:0] lcg_state;
  logic [63:0] owed_draws[$];

  // Advance the generator one step and return its top nbits
  function automatic logic [63:0] next_bits(int unsigned nbits);
    logic [47:0] mult;
    mult      = 48'(lcg48_pkg::LCG_MULT);
    lcg_state = lcg_state * mult + lcg48_pkg::LCG_ADD;
    return 64'(lcg_state >> (48 - nbits));
  endfunction

  function automatic logic [63:0] sign_ext32(logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  // Bounded int: multiply-and-shift for powers of two (zero included), else
  // modulo with redraw while the signed 32-bit overflow test trips
  function automatic logic [63:0] bounded_draw(logic [30:0] bound);
    logic [63:0] b;
    logic [63:0] r;
    logic [63:0] v;
    b = 64'(bound);
    if ((b & (b - 64'd1)) == 64'd0) return (b * next_bits(31)) >> 31;
    do begin
      r = next_bits(31);
      v = r % b;
    end while (r - v + b - 64'd1 > 64'h7FFF_FFFF);
    return v;
  endfunction

  // Apply one request to the predicted state; return 1 when it yields a draw
  function automatic bit compute_draw(logic [2:0] action, logic [63:0] seed,
                                      logic [30:0] bound, output logic [63:0] value);
    logic [63:0] hi;
    logic [63:0] lo;
    value = '0;
    case (action)
      lcg48_pkg::ACT_SEED: begin
        lcg_state = seed[47:0] ^ 48'(lcg48_pkg::LCG_MULT);
        return 1'b0;
      end
      lcg48_pkg::ACT_INT:  value = sign_ext32(next_bits(32));
      lcg48_pkg::ACT_BND:  value = bounded_draw(bound);
      lcg48_pkg::ACT_LONG: begin
        hi    = next_bits(32);
        lo    = next_bits(32);
        value = (hi << 32) + sign_ext32(lo);
      end
      lcg48_pkg::ACT_BOOL: value = next_bits(1);
      lcg48_pkg::ACT_FLT:  value = next_bits(26);
      lcg48_pkg::ACT_DBL:  begin
        hi    = next_bits(26);
        lo    = next_bits(27);
        value = (hi << 27) + lo;
      end
      default:  return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches_o++;
    if (mismatches_o <= 10)
      $display("%0t: %s: expected %h, got %h", $time, what, want, got);
  endtask

  // Predict on each request transfer, compare on each draw transfer
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    logic [63:0] value;
    logic [63:0] want;
    if (!rst_ni) begin
      lcg_state    = 48'(lcg48_pkg::LCG_MULT);
      mismatches_o = 0;
      owed_draws.delete();
    end else begin
      if (req_valid_i && req_ready_i) begin
        if (compute_draw(req_action_i, req_data_i[63:0], req_data_i[94:64], value))
          owed_draws.push_back(value);
      end
      if (draw_valid_i && draw_ready_i) begin
        if (owed_draws.size() == 0) begin
          note_mismatch("draw with none pending", '0, draw_data_i);
        end else begin
          want = owed_draws.pop_front();
          if (draw_data_i !== want) note_mismatch("draw value", want, draw_data_i);
        end
      end
    end
    pending_o = owed_draws.size();
  end

endmodule

@@ bench/tb_lcg48_random_draw_unit.sv @@
// Testbench top for the 48-bit LCG draw unit: clock, reset, request stimulus, output
// back-pressure and the verdict. Depends on lcg48_pkg, the block and lcg48_draw_checker.
module tb_lcg48_random_draw_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STUCK_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 1400;
  // Requests during which neither side idles
  localparam int CALM_FIRST   = 600;
  localparam int CALM_LAST    = 900;
  // Long receiver hold-off
  localparam int HOLD_AT      = 350;
  localparam int HOLD_CYCLES  = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;   // seed_value[63:0], bound[94:64], zero[95]
  logic [2:0]  s_axis_tuser;   // action[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // value[63:0]

  int mismatches;
  int pending;
  int requests_sent;
  int stuck_cycles = 0;

  lcg48_random_draw_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  lcg48_draw_checker draw_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .req_action_i (s_axis_tuser),
    .draw_valid_i (m_axis_tvalid),
    .draw_ready_i (m_axis_tready),
    .draw_data_i  (m_axis_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Clock: 12 ns period
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Reset: hold low after start, release once at a falling clock edge
  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic bit calm_window();
    return requests_sent >= CALM_FIRST && requests_sent < CALM_LAST;
  endfunction

  // Offer one request, with an occasional gap ahead of it, and wait for its transfer
  task automatic offer_request(logic [2:0] action, logic [63:0] seed, logic [30:0] bound);
    int gap;
    gap = (!calm_window() && $urandom_range(99) < 6) ? $urandom_range(1, 3) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= action;
    s_axis_tdata  <= {1'b0, bound, seed};
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
  endtask

  // Bounds: powers of two (zero among them), small, anything, and just above 2^30
  // where about half of the draws are rejected
  function automatic logic [30:0] pick_bound();
    case ($urandom_range(3))
      0:       return 31'(64'd1 << $urandom_range(31));
      1:       return 31'($urandom_range(1, 100));
      2:       return 31'($urandom);
      default: return 31'(32'h4000_0000 + $urandom_range(1, 1 << 20));
    endcase
  endfunction

  // Request stimulus and verdict
  initial begin : stimulus
    logic [2:0]  action;
    int          pick;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = lcg48_pkg::ACT_NONE;
    s_axis_tdata  = '0;
    requests_sent = 0;
    @(posedge rst_ni);

    // Directed: reset state, every action, seed extremes, bound corner cases
    offer_request(lcg48_pkg::ACT_INT,  '0, '0);
    offer_request(lcg48_pkg::ACT_SEED, '0, '0);
    offer_request(lcg48_pkg::ACT_INT,  '0, '0);
    offer_request(lcg48_pkg::ACT_BOOL, '0, '0);
    offer_request(lcg48_pkg::ACT_FLT,  '0, '0);
    offer_request(lcg48_pkg::ACT_DBL,  '0, '0);
    offer_request(lcg48_pkg::ACT_LONG, '0, '0);
    offer_request(lcg48_pkg::ACT_SEED, '1, '1);
    offer_request(lcg48_pkg::ACT_BND,  '0, 31'd0);
    offer_request(lcg48_pkg::ACT_BND,  '0, 31'd1);
    offer_request(lcg48_pkg::ACT_BND,  '0, 31'h4000_0000);
    offer_request(lcg48_pkg::ACT_BND,  '0, 31'h7FFF_FFFF);
    offer_request(lcg48_pkg::ACT_BND,  '0, 31'd3);
    offer_request(lcg48_pkg::ACT_BND,  '0, 31'h4000_0001);
    offer_request(lcg48_pkg::ACT_BND,  '0, 31'h4000_0001);
    offer_request(lcg48_pkg::ACT_NONE, '1, '1);
    offer_request(lcg48_pkg::ACT_INT,  '0, '0);
    offer_request(lcg48_pkg::ACT_SEED, {$urandom, $urandom}, '0);
    offer_request(lcg48_pkg::ACT_LONG, '0, '0);
    offer_request(lcg48_pkg::ACT_DBL,  '0, '0);
    offer_request(lcg48_pkg::ACT_BOOL, '0, '0);

    // Random: mostly draws, with occasional reseeds and ignored actions
    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 4)      action = lcg48_pkg::ACT_SEED;
      else if (pick < 6) action = lcg48_pkg::ACT_NONE;
      else action = 3'($urandom_range(lcg48_pkg::ACT_INT, lcg48_pkg::ACT_DBL));
      offer_request(action, {$urandom, $urandom}, pick_bound());
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // Drain the owed draws, then let the last request settle
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("lcg48_random_draw_unit: match");
    end else begin
      $display("lcg48_random_draw_unit: mismatch");
    end
    $finish;
  end

  // Output back-pressure: random stalls, one long hold-off, a calm stretch
  initial begin : sink
    bit held;
    int hold_left;
    held          = 1'b0;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && requests_sent >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (calm_window()) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 6);
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("lcg48_random_draw_unit: mismatch");
        $finish;
      end
    end
  end

endmodule
